FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line stepper check failed");

// Consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line stepper check failed");

`endif

FILE: rtl/lps_pkg.sv
`timescale 1ns / 1ps
package lps_pkg;

   localparam int COORD_BITS = 12;
   localparam int SURF_BITS  = 12;
   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int CMP_BITS   = (COORD_BITS > SURF_BITS) ? COORD_BITS : SURF_BITS;
   localparam int COLOR_BITS = 32;

   localparam logic [SURF_BITS-1:0] SURFACE_WIDTH_RESET  = SURF_BITS'(640);
   localparam logic [SURF_BITS-1:0] SURFACE_HEIGHT_RESET = SURF_BITS'(480);

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_TICK  = 1'b1
   } action_type;

   typedef enum logic {
      CSR_SURFACE_WIDTH  = 1'b0,
      CSR_SURFACE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [SURF_BITS-1:0]         surf_type;
   typedef logic [COLOR_BITS-1:0]        color_type;

   typedef struct packed {
      action_type action;
      coord_type  start_x;
      coord_type  start_y;
      coord_type  end_x;
      coord_type  end_y;
      color_type  pixel_color;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      color_type out_color;
      logic      inside_res;
      logic      last;
   } rsp_type;

   // Step unit to output register: one pixel beat per cycle at most.
   typedef struct packed {
      logic    emit;
      rsp_type data;
   } step_out_type;

endpackage

FILE: rtl/lps_step.sv
`timescale 1ns / 1ps
module lps_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  lps_pkg::req_type    req,
   input  lps_pkg::surf_type   surface_width,
   input  lps_pkg::surf_type   surface_height,
   output lps_pkg::step_out_type step_out
);

   lps_pkg::coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   lps_pkg::coord_type target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic [lps_pkg::COORD_BITS-1:0] span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic signed [lps_pkg::ERR_BITS-1:0] error_ff, error_in;
   lps_pkg::color_type color_ff, color_in;
   logic active_ff, active_in;

   logic signed [lps_pkg::COORD_BITS:0] diff_x, diff_y, abs_x, abs_y;
   logic signed [lps_pkg::ERR_BITS:0] err_ext, e2, sx_ext, sy_ext;
   logic move_x, move_y, done;
   lps_pkg::coord_type next_x, next_y;
   logic [lps_pkg::COORD_BITS-1:0] px_u, py_u;
   logic on_surface;

   function automatic lps_pkg::coord_type step_toward(lps_pkg::coord_type c,
                                                      lps_pkg::coord_type t);
      lps_pkg::coord_type r;
      if (c < t) begin
         r = c + lps_pkg::coord_type'(1);
      end else begin
         r = c - lps_pkg::coord_type'(1);
      end
      return r;
   endfunction

   always_comb begin
      diff_x = (lps_pkg::COORD_BITS+1)'(req.start_x) - (lps_pkg::COORD_BITS+1)'(req.end_x);
      diff_y = (lps_pkg::COORD_BITS+1)'(req.start_y) - (lps_pkg::COORD_BITS+1)'(req.end_y);
      abs_x  = diff_x[lps_pkg::COORD_BITS] ? -diff_x : diff_x;
      abs_y  = diff_y[lps_pkg::COORD_BITS] ? -diff_y : diff_y;

      err_ext = (lps_pkg::ERR_BITS+1)'(error_ff);
      e2      = err_ext <<< 1;
      sx_ext  = $signed((lps_pkg::ERR_BITS+1)'(span_x_ff));
      sy_ext  = $signed((lps_pkg::ERR_BITS+1)'(span_y_ff));
      move_x  = e2 > -sy_ext;
      move_y  = !move_x && (e2 < sx_ext);
      next_x  = move_x ? step_toward(cur_x_ff, target_x_ff) : cur_x_ff;
      next_y  = move_y ? step_toward(cur_y_ff, target_y_ff) : cur_y_ff;
      done    = (next_x == target_x_ff) && (next_y == target_y_ff);

      px_u   = cur_x_ff;
      py_u   = cur_y_ff;
      on_surface = !cur_x_ff[lps_pkg::COORD_BITS-1] && !cur_y_ff[lps_pkg::COORD_BITS-1] &&
                   (lps_pkg::CMP_BITS'(px_u) < lps_pkg::CMP_BITS'(surface_width)) &&
                   (lps_pkg::CMP_BITS'(py_u) < lps_pkg::CMP_BITS'(surface_height));
   end

   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      target_x_in = target_x_ff;
      target_y_in = target_y_ff;
      span_x_in   = span_x_ff;
      span_y_in   = span_y_ff;
      error_in    = error_ff;
      color_in    = color_ff;
      active_in   = active_ff;
      step_out.emit            = 1'b0;
      step_out.data.pixel_x    = cur_x_ff;
      step_out.data.pixel_y    = cur_y_ff;
      step_out.data.out_color  = color_ff;
      step_out.data.inside_res = on_surface;
      step_out.data.last       = done;
      if (accept) begin
         case (req.action)
            lps_pkg::ACT_START: begin
               cur_x_in    = req.start_x;
               cur_y_in    = req.start_y;
               target_x_in = req.end_x;
               target_y_in = req.end_y;
               span_x_in   = abs_x[lps_pkg::COORD_BITS-1:0];
               span_y_in   = abs_y[lps_pkg::COORD_BITS-1:0];
               error_in    = lps_pkg::ERR_BITS'(abs_x) - lps_pkg::ERR_BITS'(abs_y);
               color_in    = req.pixel_color;
               active_in   = (req.start_x != req.end_x) || (req.start_y != req.end_y);
            end
            lps_pkg::ACT_TICK: begin
               if (active_ff) begin
                  step_out.emit = 1'b1;
                  cur_x_in      = next_x;
                  cur_y_in      = next_y;
                  if (move_x) begin
                     error_in = lps_pkg::ERR_BITS'(err_ext - sy_ext);
                  end else if (move_y) begin
                     error_in = lps_pkg::ERR_BITS'(err_ext + sx_ext);
                  end
                  active_in = !done;
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      target_x_ff <= target_x_in;
      target_y_ff <= target_y_in;
      span_x_ff   <= span_x_in;
      span_y_ff   <= span_y_in;
      error_ff    <= error_in;
      color_ff    <= color_in;
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

FILE: rtl/lps_out_reg.sv
`timescale 1ns / 1ps
module lps_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  lps_pkg::step_out_type step_out,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output lps_pkg::rsp_type      rsp_payload
);

   logic             valid_ff, valid_in;
   lps_pkg::rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (step_out.emit) begin
         valid_in = 1'b1;
         data_in  = step_out.data;
      end else if (!rsp_stall) begin
         // beat taken (or none waiting): drop
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

FILE: rtl/line_pixel_stepper_core.sv
`timescale 1ns / 1ps
// Four-connected Bresenham line stepper. A start beat (action ACT_START) loads
// the endpoints and color and yields no pixel; each tick beat (ACT_TICK) while
// a line is in progress yields one pixel beat, flagged in inside_res against the
// surface size, with last set on the pixel just before the end point, which is
// itself never produced. The error update and the step are one add and compare
// ahead of the state registers, and a pixel is captured in an output register
// at the edge that accepts its tick, so it is offered on rsp in the very next
// cycle. A new beat is accepted every cycle that req_stall is low; req_stall
// rises only while a pixel waits in the output register and rsp_stall is high.
// The size registers reset to 640 by 480 and csr_ready is always high; write
// them only while the block is idle.
module line_pixel_stepper_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lps_pkg::req_type       req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lps_pkg::rsp_type       rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  lps_pkg::csr_index_type csr_index,
   input  lps_pkg::surf_type      csr_wdata
);

   lps_pkg::surf_type     surface_width_ff, surface_width_in;
   lps_pkg::surf_type     surface_height_ff, surface_height_in;
   lps_pkg::step_out_type step_out;
   logic                  accept;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      surface_width_in  = surface_width_ff;
      surface_height_in = surface_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lps_pkg::CSR_SURFACE_WIDTH:  surface_width_in  = csr_wdata;
            lps_pkg::CSR_SURFACE_HEIGHT: surface_height_in = csr_wdata;
            default: begin
               surface_width_in = surface_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_width_ff  <= lps_pkg::SURFACE_WIDTH_RESET;
         surface_height_ff <= lps_pkg::SURFACE_HEIGHT_RESET;
      end else begin
         surface_width_ff  <= surface_width_in;
         surface_height_ff <= surface_height_in;
      end
   end

   lps_step u_step (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req_payload),
      .surface_width  (surface_width_ff),
      .surface_height (surface_height_ff),
      .step_out       (step_out)
   );

   lps_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .step_out    (step_out),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/lps_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lps_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input lps_pkg::req_type       req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input lps_pkg::rsp_type       rsp_payload,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   logic start_beat, out_free, csr_write;

   assign start_beat = req_valid && !req_stall && (req_payload.action == lps_pkg::ACT_START);
   assign out_free   = !(rsp_valid && rsp_stall);
   assign csr_write  = csr_valid && csr_ready;

   `LPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `LPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))
   `LPS_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `LPS_ASSERT_NEXT(a_start_no_pixel, clock, reset, start_beat && out_free, !rsp_valid)
   `LPS_ASSERT_SAME(a_csr_always_ready, clock, reset, csr_write || !csr_write, csr_ready)

endmodule

bind line_pixel_stepper_core lps_checker u_checker (.*);
